// File: design/greedy_vertex_colouring_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy vertex colouring block
// Overlapping and next-cycle implications, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_VERTEX_COLOURING_ASSERT_SVH
`define GREEDY_VERTEX_COLOURING_ASSERT_SVH

// The condition implies the check in the same cycle.
`define GVC_ASSERT_IMP(label, cond, check) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (check)) \
        else $error("gvc: same-cycle check failed");

// The condition implies the check in the next cycle.
`define GVC_ASSERT_NXT(label, cond, check) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (check)) \
        else $error("gvc: next-cycle check failed");

`endif

// File: design/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// Constants and beat types shared by the greedy vertex colouring block.
// ----------------------------------------------------------------------------
`default_nettype none

package gvc_pkg;

    localparam int NUM_V      = 64;               // vertices and adjacency row width
    localparam int VTX_W      = $clog2(NUM_V);    // vertex index width
    localparam int COL_W      = VTX_W + 1;        // colour 0..NUM_V
    localparam int CNT_W      = 7;                // vertex_count register width
    localparam int CHUNK_W    = 8;                // free-colour search width per cycle
    localparam int CHUNK_IDXW = $clog2(CHUNK_W);
    localparam int STEPS      = NUM_V / CHUNK_W;
    localparam int STEP_W     = $clog2(STEPS);

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic [NUM_V-1:0] adjacency_row;
    } in_beat_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_out;
        logic [COL_W-1:0] assigned_colour;
        logic [COL_W-1:0] colours_used;
        logic             rejected;
    } out_beat_t;

endpackage

`default_nettype wire

// File: design/greedy_vertex_colouring.sv
// An out-of-range vertex goes from IDLE straight to FINISH; its result is registered there
// once the output is free. A vertex in range goes through SCAN, MASK and SEARCH first:
// one colour-store read per slot below the vertex count, then 8 colours per search cycle.
// One item at a time: a new beat is accepted only after the last result is registered;
// a result waiting for m_ready holds the block until it is taken.
// Reset (aresetn, synchronous, active low) clears valid bits, colour count; vertex_count = 64.
`default_nettype none

`include "greedy_vertex_colouring_assert.svh"

module greedy_vertex_colouring (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [6:0]        cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire gvc_pkg::in_beat_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output gvc_pkg::out_beat_t     m_data
);

    import gvc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MASK   = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [COL_W-1:0]  n_reg, n_next;
    logic [VTX_W-1:0]  vtx_reg, vtx_next;
    logic [NUM_V-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [NUM_V-1:0]  blocked_reg, blocked_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [COL_W-1:0]  assigned_reg, assigned_next;
    logic              rejected_reg, rejected_next;
    logic [COL_W-1:0]  max_reg, max_next;
    logic [NUM_V-1:0]  valid_reg, valid_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    logic              rd_en;
    logic [COL_W-1:0]  rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  n_eff;
    logic [CHUNK_W-1:0] chunk;
    logic              chunk_free;
    logic [CHUNK_IDXW-1:0] chunk_idx;
    logic              out_free;

    gvc_ram #(
        .WIDTH(COL_W),
        .DEPTH(NUM_V)
    ) u_colour_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(vtx_reg),
        .wr_data(assigned_reg),
        .rd_en  (rd_en),
        .rd_addr(idx_reg[VTX_W-1:0]),
        .rd_data(rd_data)
    );

    assign n_eff    = (count_reg > CNT_W'(NUM_V)) ? COL_W'(NUM_V) : COL_W'(count_reg);
    assign rd_en    = (state_reg == ST_SCAN) && (idx_reg < n_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign wr_en    = (state_reg == ST_FINISH) && out_free && (assigned_reg != '0);

    // Lowest free colour within the current chunk of the blocked mask.
    assign chunk = blocked_reg[{step_reg, {CHUNK_IDXW{1'b0}}} +: CHUNK_W];
    always_comb begin
        chunk_free = 1'b0;
        chunk_idx  = '0;
        for (int b = CHUNK_W - 1; b >= 0; b--) begin
            if (!chunk[b]) begin
                chunk_free = 1'b1;
                chunk_idx  = CHUNK_IDXW'(b);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        vtx_next      = vtx_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        blocked_next  = blocked_reg;
        step_next     = step_reg;
        assigned_next = assigned_reg;
        rejected_next = rejected_reg;
        max_next      = max_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            count_next = cfg_wr_data;
        end

        // A colour read issued last cycle lands now; mark it as taken.
        if (pend_reg && (rd_data != '0) && (rd_data <= COL_W'(NUM_V))) begin
            blocked_next[VTX_W'(rd_data - COL_W'(1))] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    vtx_next      = s_data.vertex_index;
                    row_next      = s_data.adjacency_row;
                    n_next        = n_eff;
                    idx_next      = '0;
                    blocked_next  = '0;
                    step_next     = '0;
                    assigned_next = '0;
                    if ({1'b0, s_data.vertex_index} >= n_eff) begin
                        rejected_next = 1'b1;
                        state_next    = ST_FINISH;
                    end else begin
                        rejected_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg < n_reg) begin
                    pend_next = row_reg[idx_reg[VTX_W-1:0]] && valid_reg[idx_reg[VTX_W-1:0]];
                    idx_next  = idx_reg + COL_W'(1);
                end else begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK: begin
                // Colours above the effective count are outside the search.
                for (int i = 0; i < NUM_V; i++) begin
                    if (COL_W'(i) >= n_reg) begin
                        blocked_next[i] = 1'b1;
                    end
                end
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (chunk_free) begin
                    assigned_next = {1'b0, step_reg, chunk_idx} + COL_W'(1);
                    state_next    = ST_FINISH;
                end else if (step_reg == STEP_W'(STEPS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (assigned_reg > max_reg) begin
                        max_next = assigned_reg;
                    end
                    if (assigned_reg != '0) begin
                        valid_next[vtx_reg] = 1'b1;
                    end
                    m_data_next.vertex_out      = vtx_reg;
                    m_data_next.assigned_colour = assigned_reg;
                    m_data_next.colours_used    = (assigned_reg > max_reg) ? assigned_reg : max_reg;
                    m_data_next.rejected        = rejected_reg;
                    m_valid_next                = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_W'(NUM_V);
            max_reg     <= '0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            max_reg     <= max_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        vtx_reg      <= vtx_next;
        row_reg      <= row_next;
        idx_reg      <= idx_next;
        blocked_reg  <= blocked_next;
        step_reg     <= step_next;
        assigned_reg <= assigned_next;
        rejected_reg <= rejected_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GVC_ASSERT_IMP(a_reject_no_colour, m_valid && m_data.rejected, m_data.assigned_colour == '0)
    `GVC_ASSERT_IMP(a_colour_in_count, m_valid, m_data.assigned_colour <= m_data.colours_used)
    `GVC_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `GVC_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, idx_reg <= n_reg)

endmodule

`default_nettype wire

// File: design/gvc_ram.sv
// ----------------------------------------------------------------------------
// gvc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gvc_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: tb/greedy_vertex_colouring_tb.sv
// ----------------------------------------------------------------------------
// Testbench for greedy_vertex_colouring
// Drives vertex beats with random gaps and checks every result beat against
// a first-fit colouring predictor. The vertex count is changed while the
// block is idle, and that covers the zero, one, full and over-range values.
// ----------------------------------------------------------------------------
module greedy_vertex_colouring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gvc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 900;
    localparam logic [NUM_V-1:0] ALL_ONES = {NUM_V{1'b1}};

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_beat_t         s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_beat_t        m_data;

    in_beat_t  pending_vertices[$];
    out_beat_t expected_colourings[$];

    // Shadow of the block's colour store, colour count and vertex count.
    logic [COL_W-1:0] colour_of [NUM_V] = '{default: '0};
    logic [COL_W-1:0] top_colour   = '0;
    logic [CNT_W-1:0] vertex_limit = 7'd64;

    int send_gap    = 0;
    int recv_gap    = 0;
    int send_max    = 4;
    int recv_max    = 4;
    int mismatches  = 0;
    int cycle_count = 0;

    greedy_vertex_colouring uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Gives the vertex the lowest colour that no coloured neighbour in range holds.
    function automatic out_beat_t colour_vertex(in_beat_t beat);
        int               n;
        int               pick;
        logic [NUM_V-1:0] blocked;
        out_beat_t        res;
        n = (vertex_limit > NUM_V) ? NUM_V : int'(vertex_limit);
        pick = 0;
        res.vertex_out = beat.vertex_index;
        res.rejected = (int'(beat.vertex_index) >= n);
        if (!res.rejected) begin
            blocked = '0;
            for (int j = 0; j < n; j++) begin
                if (beat.adjacency_row[j] && colour_of[j] != 0) begin
                    blocked[colour_of[j] - 1] = 1'b1;
                end
            end
            for (int k = n; k >= 1; k--) begin
                if (!blocked[k - 1]) begin
                    pick = k;
                end
            end
            if (pick != 0) begin
                colour_of[beat.vertex_index] = COL_W'(pick);
                if (pick > int'(top_colour)) begin
                    top_colour = COL_W'(pick);
                end
            end
        end
        res.assigned_colour = COL_W'(pick);
        res.colours_used = top_colour;
        return res;
    endfunction

    function automatic logic [NUM_V-1:0] random_row(int density);
        logic [NUM_V-1:0] a;
        logic [NUM_V-1:0] b;
        logic [NUM_V-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            0: begin
                return a & b & c;
            end
            1: begin
                return a;
            end
            2: begin
                return a | b;
            end
            default: begin
                return ~(a & b & c);
            end
        endcase
    endfunction

    task automatic queue_vertex(input logic [VTX_W-1:0] v, input logic [NUM_V-1:0] row);
        in_beat_t beat;
        beat.vertex_index = v;
        beat.adjacency_row = row;
        pending_vertices = {pending_vertices, beat};
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_vertices.size() != 0 || s_valid || expected_colourings.size() != 0);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vertex_limit = value;
        @(negedge aclk);
    endtask

    // Vertex beat driver: a new beat goes out only after its drawn gap has passed.
    always @(posedge aclk) begin : vertex_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_colourings = {expected_colourings, colour_vertex(s_data)};
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_vertices.size() != 0) begin
                    s_data <= pending_vertices.pop_front();
                    s_valid <= 1'b1;
                    send_gap <= $urandom_range(0, send_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        out_beat_t want;
        int        stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_colourings.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("unexpected result beat: vertex %0d colour %0d used %0d rej %0b",
                                 m_data.vertex_out, m_data.assigned_colour,
                                 m_data.colours_used, m_data.rejected);
                    end
                    mismatches++;
                end else begin
                    want = expected_colourings.pop_front();
                    if (m_data.vertex_out !== want.vertex_out
                            || m_data.assigned_colour !== want.assigned_colour
                            || m_data.colours_used !== want.colours_used
                            || m_data.rejected !== want.rejected) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("mismatch: expected vertex %0d colour %0d used %0d rej %0b",
                                     want.vertex_out, want.assigned_colour,
                                     want.colours_used, want.rejected);
                            $display("          actual   vertex %0d colour %0d used %0d rej %0b",
                                     m_data.vertex_out, m_data.assigned_colour,
                                     m_data.colours_used, m_data.rejected);
                        end
                        mismatches++;
                    end
                end
                stall = $urandom_range(0, recv_max);
                recv_gap <= stall;
                m_ready <= (stall == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= (recv_gap == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int               random_items;
        int               n;
        int               cnt;
        int               pick;
        logic [CNT_W-1:0] count_value;
        logic [VTX_W-1:0] v;
        logic [NUM_V-1:0] row;
        random_items = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset count of 64: recolouring, the self bit and the top vertex.
        queue_vertex(6'd0, '0);
        queue_vertex(6'd63, ALL_ONES);
        queue_vertex(6'd63, ALL_ONES);
        queue_vertex(6'd5, NUM_V'(1) << 63);
        queue_vertex(6'd0, NUM_V'(33));

        // One vertex: stale colour above range, no colour free, rejection.
        write_vertex_count(7'd1);
        queue_vertex(6'd0, ALL_ONES);
        queue_vertex(6'd0, NUM_V'(1));
        queue_vertex(6'd1, '0);
        queue_vertex(6'd63, ALL_ONES);

        // A count of zero rejects every vertex.
        write_vertex_count(7'd0);
        queue_vertex(6'd0, ALL_ONES);

        // Over-range count behaves as 64.
        write_vertex_count(7'd127);
        queue_vertex(6'd63, '0);
        queue_vertex(6'd62, (NUM_V'(1) << 63) | NUM_V'(1));

        // Two vertices: out-of-range adjacency bits ignored, both colours blocked.
        write_vertex_count(7'd2);
        queue_vertex(6'd0, '0);
        queue_vertex(6'd1, NUM_V'(1));
        queue_vertex(6'd0, NUM_V'(3));
        queue_vertex(6'd1, ALL_ONES ^ NUM_V'(1));
        queue_vertex(6'd2, ALL_ONES);

        // The sender holds off here until all results are back.
        write_vertex_count(7'd64);
        queue_vertex(6'd32, random_row(1));
        queue_vertex(6'd31, random_row(3));

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0: count_value = 7'd0;
                1: count_value = 7'd1;
                2: count_value = 7'd2;
                3: count_value = 7'd127;
                4: count_value = CNT_W'($urandom_range(65, 127));
                5, 6, 7: count_value = CNT_W'($urandom_range(3, 63));
                default: count_value = 7'd64;
            endcase
            write_vertex_count(count_value);
            send_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            recv_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            n = (count_value > NUM_V) ? NUM_V : int'(count_value);
            if (n > 0 && $urandom_range(0, 3) == 0) begin
                // Dense sweep in index order drives the colours toward n.
                for (int i = 0; i < n; i++) begin
                    row = ($urandom_range(0, 7) == 0) ? random_row(3) : ALL_ONES;
                    queue_vertex(VTX_W'(i), row);
                end
                random_items += n;
            end else begin
                cnt = (n == 0) ? 4 : $urandom_range(10, 40);
                for (int i = 0; i < cnt; i++) begin
                    if (n > 0 && $urandom_range(0, 7) != 0) begin
                        v = VTX_W'($urandom_range(0, n - 1));
                    end else begin
                        v = VTX_W'($urandom_range(0, NUM_V - 1));
                    end
                    queue_vertex(v, random_row($urandom_range(0, 3)));
                end
                random_items += cnt;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_colourings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: greedy_vertex_colouring.f
+incdir+design
design/gvc_pkg.sv
design/gvc_ram.sv
design/greedy_vertex_colouring.sv
tb/greedy_vertex_colouring_tb.sv
